### sv/pflr_pkg.sv
// Shared constants and result type for the LFU page-frame replacement block.
`timescale 1ns / 1ps

package pflr_pkg;

  // Elements per page and number of resident frames.
  localparam int PAGE_ELEMENTS = 100;
  localparam int FRAME_COUNT   = 4;

  localparam int INDEX_W     = 20;
  localparam int PAGE_W      = 14;
  localparam int COUNT_W     = 16;
  localparam int FRAME_OUT_W = 2;
  localparam int FRAME_W     = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;

  localparam int IN_TDATA_W  = ((INDEX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 32;

  // Ceiling division: (index + PAGE_ELEMENTS - 1) / PAGE_ELEMENTS, done as a
  // multiply by a rounded-up reciprocal. The shift leaves enough headroom that
  // the quotient is exact for every sum below 2**SUM_W.
  localparam int SUM_W     = INDEX_W + 1;
  localparam int DIV_SHIFT = SUM_W + $clog2(PAGE_ELEMENTS);
  localparam int RECIP_W   = SUM_W + 2;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) / PAGE_ELEMENTS) + 64'd1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Result beat, first member in the highest bits so hit lands in bit 0.
  typedef struct packed {
    logic [PAGE_W-1:0]      evicted_page;
    logic                   evicted;
    logic [PAGE_W-1:0]      page_number;
    logic [FRAME_OUT_W-1:0] frame;
    logic                   hit;
  } pflr_result_t;

endpackage

### sv/pflr_page_div.sv
// Two-stage page number unit: ceiling divide of the element index by the page size.
`timescale 1ns / 1ps

module pflr_page_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pflr_pkg::INDEX_W-1:0] in_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pflr_pkg::PAGE_W-1:0]  out_page
);
  import pflr_pkg::*;

  logic              sum_valid;
  logic [SUM_W-1:0]  sum;
  logic              prod_valid;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_next;
  logic [PROD_W-1:0] quot;
  logic              sum_ready;
  logic              prod_ready;

  assign prod_ready = !prod_valid || out_ready;
  assign sum_ready  = !sum_valid || prod_ready;
  assign in_ready   = sum_ready;

  assign prod_next = PROD_W'(sum) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid  <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      if (sum_ready) begin
        sum_valid <= in_valid;
      end
      if (prod_ready) begin
        prod_valid <= sum_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ready && in_valid) begin
      sum <= SUM_W'(in_index) + SUM_W'(PAGE_ELEMENTS - 1);
    end
    if (prod_ready && sum_valid) begin
      prod <= prod_next;
    end
  end

  // Wide page numbers keep only their low bits.
  assign quot      = prod >> DIV_SHIFT;
  assign out_page  = quot[PAGE_W-1:0];
  assign out_valid = prod_valid;

endmodule

### sv/pflr_frame_table.sv
// Resident frame table: tag compare, LFU victim select and state update.
`timescale 1ns / 1ps

module pflr_frame_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        access,
  input  logic [pflr_pkg::PAGE_W-1:0] page,
  output pflr_pkg::pflr_result_t      result
);
  import pflr_pkg::*;

  logic [PAGE_W-1:0]  frame_page [FRAME_COUNT];
  logic [COUNT_W-1:0] use_count  [FRAME_COUNT];
  logic [FRAME_COUNT-1:0] frame_valid;

  logic               hit_found;
  logic [FRAME_W-1:0] hit_idx;
  logic               empty_found;
  logic [FRAME_W-1:0] empty_idx;
  logic [FRAME_W-1:0] lfu_idx;
  logic [COUNT_W-1:0] lfu_count;
  logic [FRAME_W-1:0] sel_idx;
  logic               evicting;

  always_comb begin
    hit_found   = 1'b0;
    hit_idx     = '0;
    empty_found = 1'b0;
    empty_idx   = '0;
    // Scan downward so the lowest matching or empty frame wins.
    for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
      if (frame_valid[i] && frame_page[i] == page) begin
        hit_found = 1'b1;
        hit_idx   = FRAME_W'(i);
      end
      if (!frame_valid[i]) begin
        empty_found = 1'b1;
        empty_idx   = FRAME_W'(i);
      end
    end
    // Least-used frame; strict compare keeps the lowest index on a tie.
    lfu_idx   = '0;
    lfu_count = use_count[0];
    for (int i = 1; i < FRAME_COUNT; i++) begin
      if (use_count[i] < lfu_count) begin
        lfu_idx   = FRAME_W'(i);
        lfu_count = use_count[i];
      end
    end
  end

  assign evicting = !hit_found && !empty_found;
  assign sel_idx  = hit_found ? hit_idx : (empty_found ? empty_idx : lfu_idx);

  always_comb begin
    result.hit          = hit_found;
    result.frame        = FRAME_OUT_W'(sel_idx);
    result.page_number  = page;
    result.evicted      = evicting;
    result.evicted_page = evicting ? frame_page[lfu_idx] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
    end else if (access && !hit_found) begin
      frame_valid[sel_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (access) begin
      if (hit_found) begin
        if (use_count[sel_idx] != COUNT_MAX) begin
          use_count[sel_idx] <= use_count[sel_idx] + COUNT_W'(1);
        end
      end else begin
        frame_page[sel_idx] <= page;
        use_count[sel_idx]  <= COUNT_W'(1);
      end
    end
  end

endmodule

### sv/page_frame_lfu_replacement.sv
// Top level of the four-frame LFU page replacement block.
`timescale 1ns / 1ps

// Each input beat carries one element index; the block turns it into a page
// number (index divided by the page size, rounded up) and looks it up among
// the resident frames. A hit bumps that frame's use count, saturating at
// all ones. A miss loads the page into the lowest empty frame, or, with all
// frames full, replaces the least-used frame (lowest index on a tie) and
// reports the page it dropped; a loaded frame starts with a count of one.
// Exactly one result beat leaves for every input beat, in order. The block
// takes one beat per clock unless the output stalls: the divide runs in two
// registered stages (an add, then a multiply by a reciprocal), and the frame
// compare, victim pick and table update happen in the same cycle, into the
// output register, so back-to-back accesses always see the table state left
// by the one before. An input beat passes the sum, product and output
// registers in turn. All stages hold while the output register is full and
// not taken; reset empties all frames at once, with no clearing pass.
module page_frame_lfu_replacement (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // element_index[19:0], zero pad above
  input  logic [pflr_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // hit[0], frame[2:1], page_number[16:3], evicted[17], evicted_page[31:18]
  output logic [pflr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import pflr_pkg::*;

  logic              div_valid;
  logic [PAGE_W-1:0] div_page;
  logic              out_ready;
  logic              access;
  pflr_result_t      result;
  pflr_result_t      out_beat;

  // Output register frees up when empty or when its beat is taken.
  assign out_ready = !m_axis_tvalid || m_axis_tready;
  // Commit a table access only when its result can move into the output.
  assign access    = div_valid && out_ready;

  pflr_page_div u_page_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_index  (s_axis_tdata[INDEX_W-1:0]),
    .out_valid (div_valid),
    .out_ready (out_ready),
    .out_page  (div_page)
  );

  pflr_frame_table u_frame_table (
    .clk    (clk),
    .rst    (rst),
    .access (access),
    .page   (div_page),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_axis_tvalid <= div_valid;
    end
  end

  // Hold the result payload while the beat waits downstream.
  always_ff @(posedge clk) begin
    if (access) begin
      out_beat <= result;
    end
  end

  assign m_axis_tdata = OUT_TDATA_W'(out_beat);

endmodule

### sv/pflr_checker.sv
// Port-level checks for the LFU page replacement block, bound to the top level.
`timescale 1ns / 1ps

module pflr_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [pflr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [pflr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // A stalled result beat holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // A hit never evicts.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[17]))
    else $error("hit reported with eviction");

  // Evicted page reads zero when nothing was evicted.
  a_evict_page_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[17] |-> m_axis_tdata[31:18] == 14'd0)
    else $error("evicted page nonzero without eviction");

endmodule

bind page_frame_lfu_replacement pflr_checker u_pflr_checker (.*);

### bench/page_frame_lfu_replacement_tb.sv
// Self-checking bench for the LFU page-frame replacement block.
`timescale 1ns / 1ps

module page_frame_lfu_replacement_tb;
  import pflr_pkg::*;

  localparam int MAX_INDEX = (1 << INDEX_W) - 1;
  localparam int MAX_PAGE  = (MAX_INDEX + PAGE_ELEMENTS - 1) / PAGE_ELEMENTS;
  localparam int RANDOM_ACCESSES = 680;
  // Back-to-back hits on one page right after the drain.
  localparam int REPEAT_HITS = 8;
  // Longest stretch with no beat on either side before the run is abandoned.
  localparam int STALL_LIMIT = 2000;
  // Margin allowed after the drain before the final check.
  localparam int TAIL_CYCLES = 12;

  typedef struct {
    logic [INDEX_W-1:0] index;
    bit                 drain_first;  // wait for every result before sending
    bit                 no_gap;       // send the next beat straight after
  } access_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  page_frame_lfu_replacement dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Frame table as the bench expects it to stand after every accepted beat.
  logic [PAGE_W-1:0]  resident_page [FRAME_COUNT];
  logic               resident_valid[FRAME_COUNT];
  logic [COUNT_W-1:0] resident_uses [FRAME_COUNT];

  access_t      pending_accesses[$];
  pflr_result_t expected_lookups[$];
  int           error_count = 0;
  int           idle_cycles = 0;
  logic         in_taken    = 1'b0;

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR at %0t ns: %s got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Look up one access in the frame table, update the table, and return the
  // result beat the block should produce for it.
  function automatic pflr_result_t lookup_page(logic [INDEX_W-1:0] index);
    pflr_result_t r;
    logic [INDEX_W:0] sum;
    int page;
    int sel;
    sel = -1;
    sum = {1'b0, index} + (INDEX_W + 1)'(PAGE_ELEMENTS - 1);
    page = int'(sum / PAGE_ELEMENTS) & ((1 << PAGE_W) - 1);
    r = '0;
    r.page_number = PAGE_W'(page);
    // Lowest matching valid frame wins.
    for (int i = FRAME_COUNT - 1; i >= 0; i--)
      if (resident_valid[i] && resident_page[i] == PAGE_W'(page))
        sel = i;
    if (sel >= 0) begin
      r.hit = 1'b1;
      if (resident_uses[sel] != COUNT_MAX)
        resident_uses[sel] = resident_uses[sel] + 1'b1;
    end else begin
      // Miss: lowest empty frame first.
      for (int i = FRAME_COUNT - 1; i >= 0; i--)
        if (!resident_valid[i])
          sel = i;
      if (sel < 0) begin
        // All full: smallest use count, lowest index on a tie.
        sel = 0;
        for (int i = 1; i < FRAME_COUNT; i++)
          if (resident_uses[i] < resident_uses[sel])
            sel = i;
        r.evicted      = 1'b1;
        r.evicted_page = resident_page[sel];
      end
      resident_page[sel]  = PAGE_W'(page);
      resident_valid[sel] = 1'b1;
      resident_uses[sel]  = COUNT_W'(1);
    end
    r.frame = FRAME_OUT_W'(sel);
    return r;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Any element index that falls on the given page.
  function automatic logic [INDEX_W-1:0] index_on_page(int page);
    int idx;
    if (page == 0)
      return '0;
    idx = (page - 1) * PAGE_ELEMENTS + $urandom_range(1, PAGE_ELEMENTS);
    if (idx > MAX_INDEX)
      idx = MAX_INDEX;
    return INDEX_W'(idx);
  endfunction

  task automatic add_access(logic [INDEX_W-1:0] index, bit drain_first = 1'b0,
                            bit no_gap = 1'b0);
    access_t a;
    a.index       = index;
    a.drain_first = drain_first;
    a.no_gap      = no_gap;
    pending_accesses.push_back(a);
  endtask

  // Driver: present accesses at the falling edge. Hold a beat until it is
  // taken, then either idle for the chosen gap or advance to the next one.
  int send_gap = 0;
  always @(negedge clk) begin
    access_t a;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_accesses.size() > 0 &&
                   !(pending_accesses[0].drain_first && expected_lookups.size() > 0)) begin
        a = pending_accesses.pop_front();
        s_axis_tdata  <= IN_TDATA_W'(a.index);
        s_axis_tvalid <= 1'b1;
        send_gap = a.no_gap ? 0 : pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random, with calm stretches where ready stays high.
  int stall_left = 0;
  int calm_left  = 0;
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (calm_left > 0) begin
      calm_left--;
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 99) < 2)
        calm_left = $urandom_range(50, 300);
      else if ($urandom_range(0, 99) < 35)
        stall_left = pick_gap();
    end
  end

  // Monitor: sample both sides at the rising edge. Check each result beat
  // against the oldest expectation, then predict the access taken this edge.
  always @(posedge clk) begin
    pflr_result_t got;
    pflr_result_t want;
    if (rst) begin
      in_taken    <= 1'b0;
      idle_cycles = 0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got = pflr_result_t'(m_axis_tdata);
        if (expected_lookups.size() == 0) begin
          report_mismatch("result beat with nothing expected, tdata", int'(m_axis_tdata), 0);
        end else begin
          want = expected_lookups.pop_front();
          if (got.hit != want.hit)
            report_mismatch("hit", got.hit, want.hit);
          if (got.frame != want.frame)
            report_mismatch("frame", got.frame, want.frame);
          if (got.page_number != want.page_number)
            report_mismatch("page_number", got.page_number, want.page_number);
          if (got.evicted != want.evicted)
            report_mismatch("evicted", got.evicted, want.evicted);
          if (got.evicted_page != want.evicted_page)
            report_mismatch("evicted_page", got.evicted_page, want.evicted_page);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_lookups.push_back(lookup_page(s_axis_tdata[INDEX_W-1:0]));
      // Watchdog: abandon the run when no beat moves for too long.
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int ws_pages[8];
    int ws_size;
    int group_len;
    int sent;
    bit calm_group;
    int slot;
    for (int i = 0; i < FRAME_COUNT; i++) begin
      resident_page[i]  = '0;
      resident_valid[i] = 1'b0;
      resident_uses[i]  = '0;
    end

    // Directed: page zero, fill all frames, hits, eviction of the least-used
    // frame, ties, extremes of the index and alternating bit patterns.
    add_access(20'd0);          // page zero is an ordinary page
    add_access(20'd1);
    add_access(20'd100);        // same page as index 1
    add_access(20'd101);
    add_access(INDEX_W'(MAX_INDEX));      // largest page
    add_access(20'd0);
    add_access(20'd200);
    add_access(20'd50);
    add_access(20'd1048500);    // full table: drop the least-used frame
    add_access(20'd300);
    add_access(INDEX_W'(MAX_INDEX));
    add_access(INDEX_W'(MAX_INDEX));
    add_access(INDEX_W'(MAX_INDEX));
    add_access(20'd400);        // tie on the lowest count: lowest frame goes
    add_access(20'd401);
    add_access(20'd99);
    add_access(20'hAAAAA);
    add_access(20'h55555);
    add_access(20'h80000);
    add_access(20'h7FFFF);
    add_access(20'd500);

    // Drain first, then hit one page back to back so its count climbs, and
    // force misses to show the busy frame is not the one replaced.
    add_access(20'd1234, 1'b1, 1'b1);
    for (int i = 0; i < REPEAT_HITS; i++)
      add_access(index_on_page(13), 1'b0, 1'b1);
    for (int i = 0; i < 8; i++)
      add_access(index_on_page(2000 + i));
    add_access(20'd1234);

    // Random: working sets of a few pages, skewed toward the first ones so
    // use counts differ, mixed with indices from the whole range.
    sent = 0;
    while (sent < RANDOM_ACCESSES) begin
      ws_size = $urandom_range(3, 7);
      for (int i = 0; i < ws_size; i++) begin
        case ($urandom_range(0, 2))
          0: ws_pages[i] = $urandom_range(0, 20);
          1: ws_pages[i] = $urandom_range(MAX_PAGE - 20, MAX_PAGE);
          default: ws_pages[i] = $urandom_range(0, MAX_PAGE);
        endcase
      end
      group_len  = $urandom_range(30, 90);
      calm_group = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < group_len; k++) begin
        if ($urandom_range(0, 99) < 80) begin
          slot = $urandom_range(0, ws_size - 1);
          if ($urandom_range(0, 1) == 1)
            slot = slot * $urandom_range(0, ws_size - 1) / ws_size;
          add_access(index_on_page(ws_pages[slot]),
                     k == 0 && $urandom_range(0, 2) == 0, calm_group);
        end else begin
          add_access(INDEX_W'($urandom_range(0, MAX_INDEX)), 1'b0, calm_group);
        end
      end
      sent += group_len;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait until every access is taken and every result has come back.
    while (pending_accesses.size() > 0 || s_axis_tvalid)
      @(posedge clk);
    while (expected_lookups.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_lookups.size() > 0)
      report_mismatch("results still outstanding", expected_lookups.size(), 0);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
